>>> hw/rtl/alpir_pkg.sv
package alpir_pkg;

    localparam int POS_W     = 5;
    localparam int VAL_W     = 32;
    localparam int OUT_IDX_W = 4;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_PRINT  = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_BADPOS = 2'd2;
    localparam logic [1:0] STAT_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_REMOVE = 2'd2,
        SH_ROTATE = 2'd3
    } shift_op_t;

    typedef struct packed {
        shift_op_t          op;
        logic [POS_W-1:0]   pos;
    } cell_ctl_t;

    typedef struct packed {
        logic [1:0]                command;
        logic [POS_W-1:0]          position;
        logic signed [VAL_W-1:0]   item_value;
    } request_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VAL_W-1:0]   out_value;
        logic [OUT_IDX_W-1:0]      out_index;
        logic                      last_result;
    } result_t;

endpackage

>>> hw/rtl/alpir_cell.sv
module alpir_cell
    import alpir_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  cell_ctl_t             ctl,
    input  logic                  tail_hit,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] head_data,
    input  logic [DATA_WIDTH-1:0] ins_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] pick
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  above_pos;
    logic                  at_pos;

    assign above_pos = (INDEX > int'(ctl.pos));
    assign at_pos    = (INDEX == int'(ctl.pos));

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            SH_INSERT:
            begin
                if (above_pos)
                begin
                    data_next = left_data;
                end
                else if (at_pos)
                begin
                    data_next = ins_data;
                end
            end
            SH_REMOVE:
            begin
                if (above_pos || at_pos)
                begin
                    data_next = right_data;
                end
            end
            SH_ROTATE:
            begin
                // tail cell wraps the head around so the list is whole again
                data_next = tail_hit ? head_data : right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign pick = at_pos ? data_reg : '0;

endmodule

>>> hw/rtl/array_list_positional_insert_remove.sv
// Ordered list kept in a row of CAPACITY cells. Insert places a value at a
// position from 0 to the current count and moves later entries up; remove
// takes out the entry at a position below the count and moves later entries
// down; both give one result beat that echoes the value. Print gives one beat
// per entry, in order, with last_result set on the final one (one error beat
// on an empty list). Full, empty and bad-position requests give one error
// beat with zero value and index and leave the list untouched; command code 3
// is dropped with no beat. For insert and remove every cell moves in parallel
// and busy stays low, so a command may follow in the next cycle. Print holds
// busy high while the cells rotate the list past cell 0, one entry per cycle,
// and ends with the list back in place. Each result beat shows on result for
// exactly one cycle with result_valid high, registered in the cycle after the
// command or rotation step that caused it; the receiver must take every beat
// as it comes, there is no way to hold results off.
module array_list_positional_insert_remove
    import alpir_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     result_valid,
    output result_t  result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PRINT = 2'b10
    } state_t;

    // control state
    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] print_idx_reg;
    logic [IDX_W-1:0] print_idx_next;
    logic             result_valid_reg;
    logic             result_valid_next;

    // result payload
    result_t          result_reg;
    result_t          result_next;

    // cell row
    cell_ctl_t             ctl;
    logic [DATA_WIDTH-1:0] ins_data;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_pick [CAPACITY];
    logic [CAPACITY-1:0]   tail_hit;
    logic [DATA_WIDTH-1:0] removed;

    logic accept;
    logic is_full;
    logic is_empty;
    logic ins_bad;
    logic rem_bad;
    logic print_last;

    // widen a stored entry to the 32-bit result field by its sign
    function automatic logic signed [VAL_W-1:0] to_out(input logic [DATA_WIDTH-1:0] v);
        logic signed [DATA_WIDTH-1:0] s;
        s = v;
        return VAL_W'(s);
    endfunction

    assign accept   = start && (state_reg == ST_IDLE);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign ins_bad  = (int'(request.position) > int'(count_reg));
    assign rem_bad  = (int'(request.position) >= int'(count_reg));
    assign ins_data = DATA_WIDTH'(request.item_value);

    assign print_last = ((int'(print_idx_reg) + 1) == int'(count_reg));

    // removed value: one-hot pick from the cell at the requested position
    always_comb
    begin
        removed = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            removed = removed | cell_pick[i];
        end
    end

    // shift command broadcast to every cell
    always_comb
    begin
        ctl.pos = request.position;
        ctl.op  = SH_HOLD;
        if (state_reg == ST_PRINT)
        begin
            ctl.op = SH_ROTATE;
        end
        else if (accept && (request.command == CMD_INSERT) && !is_full && !ins_bad)
        begin
            ctl.op = SH_INSERT;
        end
        else if (accept && (request.command == CMD_REMOVE) && !is_empty && !rem_bad)
        begin
            ctl.op = SH_REMOVE;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_in;
            logic [DATA_WIDTH-1:0] right_in;

            if (g == 0)
            begin : g_first
                assign left_in = '0;
            end
            else
            begin : g_mid_left
                assign left_in = cell_data[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_mid_right
                assign right_in = cell_data[g+1];
            end

            // tail of the occupied part during a print rotation
            assign tail_hit[g] = (count_reg == CNT_W'(g + 1));

            alpir_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (g)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .tail_hit   (tail_hit[g]),
                .left_data  (left_in),
                .right_data (right_in),
                .head_data  (cell_data[0]),
                .ins_data   (ins_data),
                .data       (cell_data[g]),
                .pick       (cell_pick[g])
            );
        end
    endgenerate

    // command decode and result beat
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        print_idx_next    = print_idx_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next.status      = STAT_OK;
                    result_next.out_value   = '0;
                    result_next.out_index   = '0;
                    result_next.last_result = 1'b1;
                    case (request.command)
                        CMD_INSERT:
                        begin
                            result_valid_next = 1'b1;
                            if (is_full)
                            begin
                                result_next.status = STAT_FULL;
                            end
                            else if (ins_bad)
                            begin
                                result_next.status = STAT_BADPOS;
                            end
                            else
                            begin
                                result_next.out_value = to_out(ins_data);
                                result_next.out_index = OUT_IDX_W'(request.position);
                                count_next            = count_reg + 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            result_valid_next = 1'b1;
                            if (is_empty)
                            begin
                                result_next.status = STAT_EMPTY;
                            end
                            else if (rem_bad)
                            begin
                                result_next.status = STAT_BADPOS;
                            end
                            else
                            begin
                                result_next.out_value = to_out(removed);
                                result_next.out_index = OUT_IDX_W'(request.position);
                                count_next            = count_reg - 1'b1;
                            end
                        end
                        CMD_PRINT:
                        begin
                            if (is_empty)
                            begin
                                result_valid_next  = 1'b1;
                                result_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                // beats come from the rotation steps
                                state_next     = ST_PRINT;
                                print_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            // unused code: no beat
                            result_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_PRINT:
            begin
                // cell 0 holds the entry at print_idx this cycle
                result_valid_next       = 1'b1;
                result_next.status      = STAT_OK;
                result_next.out_value   = to_out(cell_data[0]);
                result_next.out_index   = OUT_IDX_W'(print_idx_reg);
                result_next.last_result = print_last;
                print_idx_next          = print_idx_reg + 1'b1;
                if (print_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            print_idx_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            print_idx_reg    <= print_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy         = (state_reg == ST_PRINT);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
